[hdl/crlf_pkg.sv]
// Package: shared widths, byte constants, result kinds and result item type for the line framer.
package crlf_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 16;
    localparam int KIND_W = 2;

    localparam logic [LEN_W-1:0] MAX_LINE_RESET = LEN_W'(1000);

    localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

    localparam logic [KIND_W-1:0] KIND_DATA      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LINE_END  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TOO_LONG  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FRAME_ERR = 2'd3;

    // one result item
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  line_length;
    } result_t;

endpackage

[hdl/crlf_in_if.sv]
// Interface: valid/ready channel carrying one received byte item.
interface crlf_in_if;

    logic                    valid;
    logic                    ready;
    logic [crlf_pkg::BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);

endinterface

[hdl/crlf_out_if.sv]
// Interface: valid/ready channel carrying one framer result item.
interface crlf_out_if;

    logic                        valid;
    logic                        ready;
    logic [crlf_pkg::KIND_W-1:0] kind;
    logic [crlf_pkg::BYTE_W-1:0] data_byte;
    logic [crlf_pkg::LEN_W-1:0]  line_length;

    modport source (output valid, output kind, output data_byte, output line_length,
                    input ready);
    modport sink   (input valid, input kind, input data_byte, input line_length,
                    output ready);

endinterface

[hdl/crlf_in_stage.sv]
// Input register: captures one byte item and holds it until the framer consumes it.
module crlf_in_stage (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [crlf_pkg::BYTE_W-1:0] in_byte,
    input  logic                       consume,
    output logic                       held_valid,
    output logic [crlf_pkg::BYTE_W-1:0] held_byte
);
    import crlf_pkg::*;

    logic              valid_reg;
    logic [BYTE_W-1:0] byte_reg;

    // take a new item when empty or when the held one leaves this cycle
    assign in_ready   = !valid_reg || consume;
    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= in_byte;
        end
    end

endmodule

[hdl/crlf_frame_logic.sv]
// Framing state machine: mode, discard CR flag, content counter and the per-byte decision.
module crlf_frame_logic (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [crlf_pkg::BYTE_W-1:0] cur_byte,
    input  logic [crlf_pkg::LEN_W-1:0]  max_line,
    output logic                        res_valid,
    output crlf_pkg::result_t           res
);
    import crlf_pkg::*;

    localparam logic [1:0] MODE_NORMAL     = 2'd0;
    localparam logic [1:0] MODE_CR_PENDING = 2'd1;
    localparam logic [1:0] MODE_DISCARD    = 2'd2;
    localparam logic [1:0] MODE_ERROR      = 2'd3;

    logic [1:0]       mode_reg, mode_next;
    logic             saw_cr_reg, saw_cr_next;
    logic [LEN_W-1:0] count_reg, count_next;

    logic             is_cr;
    logic             is_lf;
    logic             too_long;
    logic [LEN_W:0]   count_plus2;

    assign is_cr       = (cur_byte == CHAR_CR);
    assign is_lf       = (cur_byte == CHAR_LF);
    assign count_plus2 = {1'b0, count_reg} + (LEN_W+1)'(2);
    assign too_long    = (count_plus2 > {1'b0, max_line});

    // per-byte decision
    always_comb
    begin
        mode_next   = mode_reg;
        saw_cr_next = saw_cr_reg;
        count_next  = count_reg;
        res_valid   = 1'b0;
        res         = '0;
        unique case (mode_reg)
            MODE_ERROR:
            begin
                res_valid = 1'b1;
                res.kind  = KIND_FRAME_ERR;
            end
            MODE_DISCARD:
            begin
                if (saw_cr_reg && is_lf)
                begin
                    mode_next   = MODE_NORMAL;
                    saw_cr_next = 1'b0;
                    count_next  = '0;
                end
                else
                begin
                    saw_cr_next = is_cr;
                end
            end
            MODE_CR_PENDING:
            begin
                res_valid = 1'b1;
                if (is_lf)
                begin
                    mode_next       = MODE_NORMAL;
                    count_next      = '0;
                    res.kind        = KIND_LINE_END;
                    res.line_length = count_reg;
                end
                else
                begin
                    mode_next = MODE_ERROR;
                    res.kind  = KIND_FRAME_ERR;
                end
            end
            default:
            begin
                if (too_long)
                begin
                    mode_next   = MODE_DISCARD;
                    saw_cr_next = is_cr;
                    count_next  = '0;
                    res_valid   = 1'b1;
                    res.kind    = KIND_TOO_LONG;
                end
                else if (is_cr)
                begin
                    mode_next = MODE_CR_PENDING;
                end
                else if (is_lf)
                begin
                    mode_next = MODE_ERROR;
                    res_valid = 1'b1;
                    res.kind  = KIND_FRAME_ERR;
                end
                else
                begin
                    count_next    = count_reg + LEN_W'(1);
                    res_valid     = 1'b1;
                    res.kind      = KIND_DATA;
                    res.data_byte = cur_byte;
                end
            end
        endcase
    end

    // state update on each consumed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_NORMAL;
            saw_cr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else if (step)
        begin
            mode_reg   <= mode_next;
            saw_cr_reg <= saw_cr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[hdl/crlf_out_reg.sv]
// Output register: holds one result item until the receiver takes it.
module crlf_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  crlf_pkg::result_t load_res,
    output logic              room,
    crlf_out_if.source        out_ch
);
    import crlf_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    // room when empty or the current item is taken this cycle
    assign room = !valid_reg || out_ch.ready;

    assign out_ch.valid       = valid_reg;
    assign out_ch.kind        = res_reg.kind;
    assign out_ch.data_byte   = res_reg.data_byte;
    assign out_ch.line_length = res_reg.line_length;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (room)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (room && load)
        begin
            res_reg <= load_res;
        end
    end

endmodule

[hdl/crlf_line_framer_core.sv]
// Top level: CRLF line framer with maximum line length check.
//
// byte_in carries one received byte per item; result_out carries one result item
// (kind, data_byte, line_length) for each byte that causes one. Bytes that cause
// no result (a CR awaiting its LF, bytes dropped after an overlong line) produce
// nothing on result_out.
// A byte accepted into the input register is decided by the framing logic, and
// its result item is loaded into the output register that drives result_out.
// Throughput: one byte per cycle while results are taken; the per-byte work is the
// mode update plus one 17-bit add and compare of the content count against max_line.
// max_line is written through cfg_we/cfg_wdata; the user must write it only while
// the block is idle (the block itself does not enforce this). It resets to 1000.
// Reset clears the input and output registers, puts the framer in normal mode
// with an empty line and clears the sticky framing error.
// When the receiver stalls, the result waits in the output register; the next
// byte still enters the input register, and bytes that produce no result keep
// flowing. byte_in.ready drops only when a result cannot be placed.
module crlf_line_framer_core (
    input  logic                        clk,
    input  logic                        rst_n,
    crlf_in_if.sink                     byte_in,
    crlf_out_if.source                  result_out,
    input  logic                        cfg_we,
    input  logic [crlf_pkg::LEN_W-1:0]  cfg_wdata
);
    import crlf_pkg::*;

    logic              held_valid;
    logic [BYTE_W-1:0] held_byte;
    logic              consume;
    logic              res_valid;
    result_t           res;
    logic              room;
    logic [LEN_W-1:0]  max_line_reg;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_line_reg <= MAX_LINE_RESET;
        end
        else if (cfg_we)
        begin
            max_line_reg <= cfg_wdata;
        end
    end

    // a held byte is decided when it makes no result or the output has room
    assign consume = held_valid && (!res_valid || room);

    crlf_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (byte_in.valid),
        .in_ready   (byte_in.ready),
        .in_byte    (byte_in.in_byte),
        .consume    (consume),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    crlf_frame_logic u_frame_logic (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (consume),
        .cur_byte  (held_byte),
        .max_line  (max_line_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    crlf_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (consume && res_valid),
        .load_res (res),
        .room     (room),
        .out_ch   (result_out)
    );

endmodule
